[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the swarm connectivity check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/scb_pkg.sv]
// ----------------------------------------------------------------------------
// scb_pkg
// Types and constants shared by the swarm connectivity check modules.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int ID_W   = 5;
  localparam int MASK_W = 16;
  localparam int CNT_W  = 8;
  localparam int LOST_W = 5;
  localparam int BETA_W = 5;
  localparam int MAX_ID = (1 << ID_W) - 1;

  localparam logic [BETA_W-1:0] BETA_RESET = 5'd1;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 8'hFF;

  localparam logic OP_BEACON = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   sender_id;
    logic              sender_lit;
    logic [MASK_W-1:0] neighbor_mask;
  } in_item_t;

  typedef struct packed {
    logic              go_back;
    logic              go_forward;
    logic [MASK_W-1:0] heard_mask;
    logic [CNT_W-1:0]  beacon_count;
    logic [LOST_W-1:0] lost_count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW,
    S_COL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic beacon;
    logic eval_start;
    logic row_step;
    logic col_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic i_lost;
    logic i_prev_lit;
    logic i_last;
    logic j_last;
    logic out_free;
  } status_t;

endpackage

[rtl/swarm_connectivity_beta_check.sv]
// ----------------------------------------------------------------------------
// swarm_connectivity_beta_check
// Beacon collector and round-end connectivity check for one swarm robot.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, in_item): a beacon item (op 0) records its
// sender as heard and ORs its neighbor mask into the sender's row and gives
// no result. An end-of-round item (op 1) scans the robot table and gives one
// result on out_valid/out_stall, out_item. Each lost unlit robot costs one
// inner pass over the table, of N = min(ROBOT_COUNT, 31) robots, through the
// single row read port. in_stall is high for the whole scan.
// Config (cfg_valid/cfg_ready, cfg_data): beta threshold, always ready; write
// it only while the block is idle.
// Reset (rst_n, synchronous): status tables and counters clear, beta to 1.
// A stalled result holds in the output register; beacons are still taken,
// and the next round end is scanned; its result waits until that one is taken.
// ----------------------------------------------------------------------------
module swarm_connectivity_beta_check #(
  parameter int ROBOT_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  scb_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output scb_pkg::out_item_t         out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scb_pkg::BETA_W-1:0] cfg_data
);
  import scb_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  scb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_item.op),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  scb_dp #(
    .ROBOT_COUNT (ROBOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/scb_ctrl.sv]
// ----------------------------------------------------------------------------
// scb_ctrl
// Sequencer: takes items, walks the robot table at round end, issues results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_stall,
  input  scb_pkg::status_t st,
  output scb_pkg::cmd_t    cmd
);
  import scb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == OP_BEACON) begin
            cmd.beacon = 1'b1;
          end else begin
            cmd.eval_start = 1'b1;
            state_nxt      = S_ROW;
          end
        end
      end
      S_ROW: begin
        cmd.row_step = 1'b1;
        if (st.i_lost && !st.i_prev_lit) begin
          state_nxt = S_COL;
        end else if (st.i_last) begin
          state_nxt = S_DONE;
        end
      end
      S_COL: begin
        cmd.col_step = 1'b1;
        if (st.j_last) begin
          state_nxt = st.i_last ? S_DONE : S_ROW;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_col_only_lost_unlit, clk, rst_n, state_r == S_COL, st.i_lost && !st.i_prev_lit)
  `ASSERT_IMPLIES(a_single_cmd, clk, rst_n, 1'b1, $onehot0({cmd.beacon, cmd.eval_start, cmd.row_step, cmd.col_step, cmd.finish}))

endmodule

[rtl/scb_dp.sv]
// ----------------------------------------------------------------------------
// scb_dp
// Datapath: heard tables, round counters, coverage scan and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scb_dp #(
  parameter int ROBOT_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scb_pkg::in_item_t             in_item,
  input  logic                          cfg_we,
  input  logic [scb_pkg::BETA_W-1:0]    cfg_data,
  input  scb_pkg::cmd_t                 cmd,
  output scb_pkg::status_t              st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output scb_pkg::out_item_t            out_item
);
  import scb_pkg::*;

  localparam int NUM    = (ROBOT_COUNT < MAX_ID) ? ROBOT_COUNT : MAX_ID;
  localparam int IDX_W  = (NUM > 1) ? $clog2(NUM) : 1;
  localparam int ROW_W  = (NUM < MASK_W) ? NUM : MASK_W;
  localparam int RIDX_W = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int SH_W   = $clog2(NUM + 1);
  localparam int CMP_W  = ((SH_W > BETA_W) ? SH_W : BETA_W) + 1;
  localparam logic [IDX_W:0]   ROW_LIM  = (IDX_W + 1)'(ROW_W);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM - 1);
  localparam logic [ID_W-1:0]  ID_LAST  = ID_W'(NUM);

  logic [NUM-1:0]    heard_r, lit_r, prev_heard_r, prev_lit_r;
  logic [ROW_W-1:0]  rows_r [NUM];
  logic [CNT_W-1:0]  beacons_r, prev_beacons_r;
  logic [BETA_W-1:0] beta_r;
  logic [IDX_W-1:0]  i_r, j_r;
  logic [SH_W-1:0]   shared_r;
  logic [LOST_W-1:0] lost_r;
  logic              back_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              id_ok;
  logic [ID_W-1:0]   id_m1;
  logic [IDX_W-1:0]  widx;
  logic              wr_en;
  logic [ROW_W-1:0]  row_j;
  logic              hit;
  logic [SH_W-1:0]   shared_sum;
  logic              shared_low;
  logic [MASK_W-1:0] heard_mask;

  assign id_ok = (in_item.sender_id != '0) && (in_item.sender_id <= ID_LAST);
  assign id_m1 = in_item.sender_id - ID_W'(1);
  assign widx  = id_m1[IDX_W-1:0];
  assign wr_en = cmd.beacon && id_ok;

  assign row_j      = rows_r[j_r];
  assign hit        = heard_r[j_r] && !lit_r[j_r] && ({1'b0, i_r} < ROW_LIM)
                      && row_j[i_r[RIDX_W-1:0]];
  assign shared_sum = shared_r + SH_W'(hit);
  assign shared_low = CMP_W'(shared_sum) <= CMP_W'(beta_r);

  always_comb begin
    heard_mask            = '0;
    heard_mask[ROW_W-1:0] = heard_r[ROW_W-1:0];
  end

  always_comb begin
    st.i_lost     = prev_heard_r[i_r] && !heard_r[i_r];
    st.i_prev_lit = prev_lit_r[i_r];
    st.i_last     = (i_r == IDX_LAST);
    st.j_last     = (j_r == IDX_LAST);
    st.out_free   = !out_valid_r || !out_stall;
  end

  // status tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heard_r        <= '0;
      lit_r          <= '0;
      prev_heard_r   <= '0;
      prev_lit_r     <= '0;
      beacons_r      <= '0;
      prev_beacons_r <= '0;
      beta_r         <= BETA_RESET;
    end else begin
      if (cfg_we) begin
        beta_r <= cfg_data;
      end
      if (cmd.finish) begin
        prev_heard_r   <= heard_r;
        prev_lit_r     <= lit_r;
        prev_beacons_r <= beacons_r;
        heard_r        <= '0;
        lit_r          <= '0;
        beacons_r      <= '0;
      end else if (wr_en) begin
        heard_r[widx] <= 1'b1;
        lit_r[widx]   <= in_item.sender_lit;
        if (beacons_r != CNT_MAX) begin
          beacons_r <= beacons_r + CNT_W'(1);
        end
      end
    end
  end

  // neighbor rows; first beacon of a round overwrites the stale row
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM; k++) begin
      if (wr_en && widx == IDX_W'(k)) begin
        rows_r[k] <= heard_r[k] ? (rows_r[k] | in_item.neighbor_mask[ROW_W-1:0])
                                : in_item.neighbor_mask[ROW_W-1:0];
      end
    end
  end

  // round-end scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r      <= '0;
      j_r      <= '0;
      shared_r <= '0;
      lost_r   <= '0;
      back_r   <= 1'b0;
    end else begin
      if (cmd.eval_start) begin
        i_r    <= '0;
        lost_r <= '0;
        back_r <= 1'b0;
      end else if (cmd.row_step) begin
        j_r      <= '0;
        shared_r <= '0;
        if (st.i_lost) begin
          lost_r <= lost_r + LOST_W'(1);
          if (st.i_prev_lit) begin
            back_r <= 1'b1;
          end
        end
        if (!(st.i_lost && !st.i_prev_lit)) begin
          i_r <= i_r + IDX_W'(1);
        end
      end else if (cmd.col_step) begin
        shared_r <= shared_sum;
        j_r      <= j_r + IDX_W'(1);
        if (st.j_last) begin
          i_r <= i_r + IDX_W'(1);
          if (shared_low) begin
            back_r <= 1'b1;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.go_back      <= back_r;
      out_r.go_forward   <= !back_r && (beacons_r > prev_beacons_r);
      out_r.heard_mask   <= heard_mask;
      out_r.beacon_count <= beacons_r;
      out_r.lost_count   <= lost_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_NEXT(a_round_cleared, clk, rst_n, cmd.finish, heard_r == '0 && beacons_r == '0)
  `ASSERT_IMPLIES(a_load_free, clk, rst_n, cmd.finish, !out_valid_r || !out_stall)

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the swarm connectivity beta check. Beacon rounds
// with random senders, lit flags and neighbor masks are closed by round-end
// items. A scoreboard predicts each round's verdict and compares it with the
// block's result. The beta threshold is swept across phases, with random
// idling on the input and the result side in all but the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  import scb_pkg::*;

  localparam int ROBOTS      = 16;
  localparam int SCAN_CYCLES = 1 + ROBOTS + ROBOTS * ROBOTS + 1 + 24;
  localparam int PHASE_ITEMS = 130;
  localparam int IN_W        = $bits(in_item_t);

  class round_scoreboard;
    localparam logic [1:0] ST_NONE  = 2'd0;
    localparam logic [1:0] ST_UNLIT = 2'd1;
    localparam logic [1:0] ST_LIT   = 2'd2;

    logic [1:0]        now_status[ROBOTS];
    logic [1:0]        last_status[ROBOTS];
    logic [MASK_W-1:0] rows[ROBOTS];
    logic [CNT_W-1:0]  beacons;
    logic [CNT_W-1:0]  last_beacons;
    logic [BETA_W-1:0] beta;
    out_item_t         verdicts[$];
    int                errors;

    function new();
      foreach (rows[i]) begin
        now_status[i]  = ST_NONE;
        last_status[i] = ST_NONE;
        rows[i]        = '0;
      end
      beacons      = '0;
      last_beacons = '0;
      beta         = BETA_RESET;
      errors       = 0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t v;
      int        lost;
      int        shared;
      int        id;
      v    = '0;
      lost = 0;
      id   = int'(it.sender_id);
      if (it.op == OP_BEACON) begin
        if (id >= 1 && id <= ROBOTS) begin
          now_status[id-1] = it.sender_lit ? ST_LIT : ST_UNLIT;
          rows[id-1]       = rows[id-1] | it.neighbor_mask;
          if (beacons != CNT_MAX) beacons++;
        end
        return;
      end
      for (int i = 0; i < ROBOTS; i++) begin
        if (now_status[i] != ST_NONE) v.heard_mask[i] = 1'b1;
        if (last_status[i] != ST_NONE && now_status[i] == ST_NONE) begin
          lost++;
          if (last_status[i] == ST_LIT) begin
            v.go_back = 1'b1;
          end else begin
            shared = 0;
            for (int j = 0; j < ROBOTS; j++)
              if (now_status[j] == ST_UNLIT && rows[j][i]) shared++;
            if (shared <= int'(beta)) v.go_back = 1'b1;
          end
        end
      end
      v.go_forward   = !v.go_back && (beacons > last_beacons);
      v.beacon_count = beacons;
      v.lost_count   = LOST_W'(lost);
      verdicts.push_back(v);
      foreach (rows[i]) begin
        last_status[i] = now_status[i];
        now_status[i]  = ST_NONE;
        rows[i]        = '0;
      end
      last_beacons = beacons;
      beacons      = '0;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb_top: unexpected result back=%0d fwd=%0d heard=%h count=%0d lost=%0d",
                   got.go_back, got.go_forward, got.heard_mask, got.beacon_count,
                   got.lost_count);
        return;
      end
      want = verdicts.pop_front();
      bad  = (got.go_back !== want.go_back) || (got.go_forward !== want.go_forward) ||
             (got.heard_mask !== want.heard_mask) ||
             (got.beacon_count !== want.beacon_count) ||
             (got.lost_count !== want.lost_count);
      if (bad) begin
        errors++;
        if (errors <= 10)
          $display("tb_top: mismatch exp %0d %0d %h %0d %0d got %0d %0d %h %0d %0d",
                   want.go_back, want.go_forward, want.heard_mask, want.beacon_count,
                   want.lost_count, got.go_back, got.go_forward, got.heard_mask,
                   got.beacon_count, got.lost_count);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BETA_W-1:0] cfg_data;

  round_scoreboard   sb;
  logic [MASK_W-1:0] crowd;
  bit                quiet;
  int                sent_items;

  swarm_connectivity_beta_check #(
    .ROBOT_COUNT(ROBOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t beacon(int id, bit lit, logic [MASK_W-1:0] m);
    in_item_t it;
    it.op            = OP_BEACON;
    it.sender_id     = ID_W'(id);
    it.sender_lit    = lit;
    it.neighbor_mask = m;
    return it;
  endfunction

  function automatic in_item_t round_end();
    in_item_t it;
    it               = in_item_t'(IN_W'($urandom));
    it.op            = OP_EVAL;
    return it;
  endfunction

  function automatic in_item_t random_beacon();
    int                id;
    int                tries;
    logic [MASK_W-1:0] m;
    if ($urandom_range(0, 9) == 0) begin
      id = $urandom_range(0, MAX_ID);
    end else begin
      id    = $urandom_range(1, ROBOTS);
      tries = 0;
      while (crowd != 0 && !crowd[id-1] && tries < 32) begin
        id = $urandom_range(1, ROBOTS);
        tries++;
      end
    end
    case ($urandom_range(0, 4))
      0:       m = MASK_W'($urandom);
      1:       m = crowd;
      2:       m = '1;
      3:       m = MASK_W'($urandom) & crowd;
      default: m = '0;
    endcase
    return beacon(id, $urandom_range(0, 3) == 0, m);
  endfunction

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    sent_items++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_beta(logic [BETA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.beta = v;
  endtask

  task automatic play_round(int beacons_in_round);
    crowd = crowd ^ MASK_W'($urandom & $urandom & $urandom);
    for (int k = 0; k < beacons_in_round; k++) send_item(random_beacon());
    send_item(round_end());
  endtask

  initial begin
    logic [BETA_W-1:0] plan[5];
    int                phase_start;
    sb         = new();
    crowd      = MASK_W'($urandom);
    quiet      = 1'b0;
    sent_items = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rounds at the reset threshold
    send_item(round_end());
    send_item(beacon(1, 1'b1, 16'h0000));
    send_item(beacon(2, 1'b0, 16'hFFFF));
    send_item(beacon(16, 1'b0, 16'hFFFF));
    send_item(beacon(0, 1'b1, 16'hFFFF));
    send_item(beacon(17, 1'b0, 16'hFFFF));
    send_item(beacon(MAX_ID, 1'b1, 16'hFFFF));
    send_item(beacon(2, 1'b1, 16'h0001));
    send_item(round_end());
    send_item(beacon(16, 1'b0, 16'h0002));
    send_item(beacon(3, 1'b0, 16'h0003));
    send_item(round_end());
    send_item(beacon(3, 1'b0, 16'h8000));
    send_item(beacon(4, 1'b0, 16'h8000));
    send_item(beacon(5, 1'b1, 16'h8000));
    send_item(round_end());
    send_item(beacon(3, 1'b0, 16'h0000));
    send_item(beacon(4, 1'b0, 16'h0000));
    send_item(round_end());
    for (int k = 6; k <= 9; k++) send_item(beacon(k, 1'b0, 16'h0000));
    send_item(round_end());
    settle();

    plan[0] = 5'd0;
    plan[1] = 5'd16;
    plan[2] = 5'd31;
    plan[3] = BETA_W'($urandom_range(2, 15));
    plan[4] = 5'd1;
    for (int p = 0; p < 5; p++) begin
      write_beta(plan[p]);
      if (p == 4) quiet = 1'b1;
      // one long round to push the beacon count into saturation
      if (p == 1) play_round(300);
      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) play_round($urandom_range(0, 14));
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
